// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks on clk_i with reset rst_ni; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising edge outside of reset.
`define WFPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check that a condition never holds outside of reset.
`define WFPS_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define WFPS_ASSERT(lbl, prop, msg)
`define WFPS_NEVER(lbl, cond, msg)
`endif
`endif

// ----- src/wfps_pkg.sv -----
// ----------------------------------------------------------------------------
// wfps_pkg
// Shared widths, register codes, reset values and structs of the steering block.
// ----------------------------------------------------------------------------
package wfps_pkg;

  localparam int GAIN_W    = 16;
  localparam int MM_W      = 13;
  localparam int SPD_W     = 8;
  localparam int LIM_W     = 4;
  localparam int STAT_W    = 8;
  localparam int MISS_W    = 4;
  localparam int ACC_W     = 32;
  localparam int FRAC_W    = 8;
  localparam int DUTY_W    = 7;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN       = 3'd0,
    CFG_DERIV_GAIN      = 3'd1,
    CFG_INTEG_GAIN      = 3'd2,
    CFG_TARGET_RANGE    = 3'd3,
    CFG_MAX_VALID_RANGE = 3'd4,
    CFG_FORWARD_SPEED   = 3'd5,
    CFG_MISS_LIMIT      = 3'd6
  } cfg_idx_e;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST       = 16'd102;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST      = 16'd154;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST      = 16'd0;
  localparam logic [MM_W-1:0]   TARGET_RANGE_RST    = 13'd150;
  localparam logic [MM_W-1:0]   MAX_VALID_RANGE_RST = 13'd420;
  localparam logic [SPD_W-1:0]  FORWARD_SPEED_RST   = 8'd50;
  localparam logic [LIM_W-1:0]  MISS_LIMIT_RST      = 4'd10;
  localparam logic [MISS_W-1:0] MISS_SAT            = 4'd15;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] deriv_gain;
    logic [GAIN_W-1:0] integ_gain;
    logic [MM_W-1:0]   target_range;
    logic [MM_W-1:0]   max_valid_range;
    logic [SPD_W-1:0]  forward_speed;   // two's complement
    logic [LIM_W-1:0]  miss_limit;
  } cfg_t;

  // Control that travels with the products to the mixing stage
  typedef struct packed {
    logic zero;     // force both motors to zero
    logic halted;
  } mid_ctl_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              fwd;
    logic              rev;
  } motor_t;

  typedef struct packed {
    logic   halted;
    motor_t m2;
    motor_t m1;
  } res_t;

endpackage

// ----- src/wfps_pd_core.sv -----
// ----------------------------------------------------------------------------
// wfps_pd_core
// Sample check, miss counting, PID state update and gain products.
// ----------------------------------------------------------------------------
module wfps_pd_core #(
  parameter int RANGE_BITS = 13,
  localparam int CMP_W = (RANGE_BITS > wfps_pkg::MM_W) ? RANGE_BITS : wfps_pkg::MM_W,
  localparam int ERR_W = CMP_W + 1,
  localparam int DIF_W = ERR_W + 1,
  localparam int PP_W  = ERR_W + wfps_pkg::GAIN_W + 1,
  localparam int PD_W  = DIF_W + wfps_pkg::GAIN_W + 1,
  localparam int PI_W  = wfps_pkg::ACC_W + wfps_pkg::GAIN_W + 1
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [RANGE_BITS-1:0]              range_i,
  input  logic [wfps_pkg::STAT_W-1:0]        status_i,
  input  wfps_pkg::cfg_t                     cfg_i,
  output logic signed [PP_W-1:0]             prod_p_o,
  output logic signed [PD_W-1:0]             prod_d_o,
  output logic signed [PI_W-1:0]             prod_i_o,
  output wfps_pkg::mid_ctl_t                 ctl_o,
  output logic                               stopped_o
);

  localparam logic signed [wfps_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(wfps_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [wfps_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(wfps_pkg::ACC_W-1){1'b0}}};

  logic signed [ERR_W-1:0]          prev_err_q, prev_err_d;
  logic signed [wfps_pkg::ACC_W-1:0] err_sum_q, err_sum_d;
  logic [wfps_pkg::MISS_W-1:0]      miss_run_q, miss_run_d;
  logic                             stopped_q, stopped_d;

  logic [CMP_W-1:0]                 range_x, tgt_x, max_x;
  logic                             miss;
  logic signed [ERR_W-1:0]          err;
  logic signed [DIF_W-1:0]          diff;
  logic signed [wfps_pkg::ACC_W:0]  sum_wide;
  logic signed [wfps_pkg::ACC_W-1:0] sum_sat;
  logic [wfps_pkg::MISS_W-1:0]      miss_inc;
  logic                             stop_now;
  wfps_pkg::mid_ctl_t               ctl_d;

  always_comb begin
    range_x  = CMP_W'(range_i);
    tgt_x    = CMP_W'(cfg_i.target_range);
    max_x    = CMP_W'(cfg_i.max_valid_range);
    miss     = (range_x > max_x) || (status_i != '0);
    err      = $signed({1'b0, tgt_x}) - $signed({1'b0, range_x});
    diff     = DIF_W'(err) - DIF_W'(prev_err_q);
    sum_wide = (wfps_pkg::ACC_W+1)'(err_sum_q) + (wfps_pkg::ACC_W+1)'(err);
    // saturate when the carry into the top bit disagrees with it
    if (sum_wide[wfps_pkg::ACC_W] != sum_wide[wfps_pkg::ACC_W-1]) begin
      sum_sat = sum_wide[wfps_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sum_sat = sum_wide[wfps_pkg::ACC_W-1:0];
    end
    miss_inc = (miss_run_q == wfps_pkg::MISS_SAT) ? miss_run_q : miss_run_q + 1'b1;
    stop_now = (miss_inc >= cfg_i.miss_limit);

    prev_err_d = prev_err_q;
    err_sum_d  = err_sum_q;
    miss_run_d = miss_run_q;
    stopped_d  = stopped_q;
    if (stopped_q) begin
      ctl_d = '{zero: 1'b1, halted: 1'b1};
    end else if (miss) begin
      miss_run_d = miss_inc;
      stopped_d  = stop_now;
      ctl_d      = '{zero: 1'b1, halted: stop_now};
    end else begin
      miss_run_d = '0;
      prev_err_d = err;
      err_sum_d  = sum_sat;
      ctl_d      = '{zero: 1'b0, halted: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
      err_sum_q  <= '0;
      miss_run_q <= '0;
      stopped_q  <= 1'b0;
    end else if (en_i) begin
      prev_err_q <= prev_err_d;
      err_sum_q  <= err_sum_d;
      miss_run_q <= miss_run_d;
      stopped_q  <= stopped_d;
    end
  end

  // Products of this sample; the integral uses the sum before this update
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_p_o <= $signed({1'b0, cfg_i.prop_gain}) * err;
      prod_d_o <= $signed({1'b0, cfg_i.deriv_gain}) * diff;
      prod_i_o <= $signed({1'b0, cfg_i.integ_gain}) * err_sum_q;
      ctl_o    <= ctl_d;
    end
  end

  assign stopped_o = stopped_q;

endmodule

// ----- src/wfps_mix.sv -----
// ----------------------------------------------------------------------------
// wfps_mix
// Scale and sum the PID terms, clamp, mix into two motor commands.
// ----------------------------------------------------------------------------
module wfps_mix #(
  parameter int RANGE_BITS = 13,
  parameter int DUTY_MAX   = 100,
  localparam int CMP_W = (RANGE_BITS > wfps_pkg::MM_W) ? RANGE_BITS : wfps_pkg::MM_W,
  localparam int ERR_W = CMP_W + 1,
  localparam int DIF_W = ERR_W + 1,
  localparam int PP_W  = ERR_W + wfps_pkg::GAIN_W + 1,
  localparam int PD_W  = DIF_W + wfps_pkg::GAIN_W + 1,
  localparam int PI_W  = wfps_pkg::ACC_W + wfps_pkg::GAIN_W + 1
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [PP_W-1:0]            prod_p_i,
  input  logic signed [PD_W-1:0]            prod_d_i,
  input  logic signed [PI_W-1:0]            prod_i_i,
  input  wfps_pkg::mid_ctl_t                ctl_i,
  input  logic [wfps_pkg::SPD_W-1:0]        forward_speed_i,
  output wfps_pkg::res_t                    res_o
);

  localparam int FW    = wfps_pkg::FRAC_W;
  localparam int SUM_W = PI_W - FW + 2;
  localparam int PWM_W = $clog2(DUTY_MAX + 1) + 1;
  localparam int MIX_W = ((PWM_W > wfps_pkg::SPD_W) ? PWM_W : wfps_pkg::SPD_W) + 1;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(DUTY_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX;
  localparam logic signed [MIX_W-1:0] MIX_MAX = MIX_W'(DUTY_MAX);
  localparam logic signed [MIX_W-1:0] MIX_MIN = -MIX_MAX;

  function automatic logic signed [MIX_W-1:0] clamp_mix(logic signed [MIX_W-1:0] v);
    logic signed [MIX_W-1:0] r;
    if (v > MIX_MAX) begin
      r = MIX_MAX;
    end else if (v < MIX_MIN) begin
      r = MIX_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic wfps_pkg::motor_t drive(logic signed [MIX_W-1:0] m);
    wfps_pkg::motor_t        r;
    logic signed [MIX_W-1:0] mag;
    mag    = m[MIX_W-1] ? -m : m;
    r.rev  = m[MIX_W-1];
    r.fwd  = !m[MIX_W-1] && (m != '0);
    r.duty = mag[wfps_pkg::DUTY_W-1:0];
    return r;
  endfunction

  logic signed [PP_W-1:0]  p_adj;
  logic signed [PD_W-1:0]  d_adj;
  logic signed [PI_W-1:0]  i_adj;
  logic signed [SUM_W-1:0] total, pwm_raw;
  logic signed [PWM_W-1:0] pwm;
  logic signed [MIX_W-1:0] fs, m1, m2;
  wfps_pkg::res_t          res_d;

  always_comb begin
    // bias negative products by 255 so the shift truncates toward zero
    p_adj   = prod_p_i + $signed(PP_W'({FW{prod_p_i[PP_W-1]}}));
    d_adj   = prod_d_i + $signed(PD_W'({FW{prod_d_i[PD_W-1]}}));
    i_adj   = prod_i_i + $signed(PI_W'({FW{prod_i_i[PI_W-1]}}));
    total   = SUM_W'($signed(p_adj[PP_W-1:FW])) + SUM_W'($signed(d_adj[PD_W-1:FW]))
            + SUM_W'($signed(i_adj[PI_W-1:FW]));
    pwm_raw = -total;
    if (pwm_raw > SUM_MAX) begin
      pwm = PWM_W'(SUM_MAX);
    end else if (pwm_raw < SUM_MIN) begin
      pwm = PWM_W'(SUM_MIN);
    end else begin
      pwm = pwm_raw[PWM_W-1:0];
    end
    fs = MIX_W'($signed(forward_speed_i));
    m1 = clamp_mix(fs - MIX_W'(pwm));
    m2 = clamp_mix(fs + MIX_W'(pwm));

    res_d.halted = ctl_i.halted;
    if (ctl_i.zero) begin
      res_d.m1 = '0;
      res_d.m2 = '0;
    end else begin
      res_d.m1 = drive(m1);
      res_d.m2 = drive(m2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

// ----- src/wall_follow_pd_steering.sv -----
// ----------------------------------------------------------------------------
// wall_follow_pd_steering
// Wall-following PID steering with differential-drive mixing of two motors.
// ----------------------------------------------------------------------------
// Result path: the input register loads at the accept edge, then the product
// register and then the result register load as the item moves on.
// Throughput: one item per cycle; a stalled result only backs up into the three
// register stages before input ready drops.
// Reset (rst_ni low, asynchronous): clear PID state, miss count, halt flag and
// stage valids; load every configuration register with its default.
`include "assert_macros.svh"

module wall_follow_pd_steering #(
  parameter int DUTY_MAX   = 100,
  parameter int RANGE_BITS = 13,
  localparam int IN_W  = ((RANGE_BITS + wfps_pkg::STAT_W + 7) / 8) * 8,
  localparam int OUT_W = (($bits(wfps_pkg::res_t) + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input samples
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // range_mm [RANGE_BITS-1:0], range_status [RANGE_BITS+7:RANGE_BITS], zero pad
  input  logic [IN_W-1:0]                   s_axis_tdata,
  // motor commands
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // motor1_reverse, motor1_forward, motor1_duty[6:0], motor2_reverse,
  // motor2_forward, motor2_duty[6:0], halted, zero pad
  output logic [OUT_W-1:0]                  m_axis_tdata,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [wfps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [wfps_pkg::CFG_W-1:0]        cfg_wdata_i
);

  localparam int CMP_W = (RANGE_BITS > wfps_pkg::MM_W) ? RANGE_BITS : wfps_pkg::MM_W;
  localparam int ERR_W = CMP_W + 1;
  localparam int DIF_W = ERR_W + 1;
  localparam int PP_W  = ERR_W + wfps_pkg::GAIN_W + 1;
  localparam int PD_W  = DIF_W + wfps_pkg::GAIN_W + 1;
  localparam int PI_W  = wfps_pkg::ACC_W + wfps_pkg::GAIN_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  wfps_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (wfps_pkg::cfg_idx_e'(cfg_idx_i))
        wfps_pkg::CFG_PROP_GAIN:       cfg_d.prop_gain       = cfg_wdata_i;
        wfps_pkg::CFG_DERIV_GAIN:      cfg_d.deriv_gain      = cfg_wdata_i;
        wfps_pkg::CFG_INTEG_GAIN:      cfg_d.integ_gain      = cfg_wdata_i;
        wfps_pkg::CFG_TARGET_RANGE:    cfg_d.target_range    = cfg_wdata_i[wfps_pkg::MM_W-1:0];
        wfps_pkg::CFG_MAX_VALID_RANGE: cfg_d.max_valid_range = cfg_wdata_i[wfps_pkg::MM_W-1:0];
        wfps_pkg::CFG_FORWARD_SPEED:   cfg_d.forward_speed   = cfg_wdata_i[wfps_pkg::SPD_W-1:0];
        wfps_pkg::CFG_MISS_LIMIT:      cfg_d.miss_limit      = cfg_wdata_i[wfps_pkg::LIM_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain       <= wfps_pkg::PROP_GAIN_RST;
      cfg_q.deriv_gain      <= wfps_pkg::DERIV_GAIN_RST;
      cfg_q.integ_gain      <= wfps_pkg::INTEG_GAIN_RST;
      cfg_q.target_range    <= wfps_pkg::TARGET_RANGE_RST;
      cfg_q.max_valid_range <= wfps_pkg::MAX_VALID_RANGE_RST;
      cfg_q.forward_speed   <= wfps_pkg::FORWARD_SPEED_RST;
      cfg_q.miss_limit      <= wfps_pkg::MISS_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: input reg -> product reg -> result reg.
  // Each stage advances when the stage after it is empty or moving.
  // --------------------------------------------------------------------------
  logic in_vld_q, in_vld_d;
  logic mid_vld_q, mid_vld_d;
  logic out_vld_q, out_vld_d;
  logic out_rdy, mid_rdy, adv_mid, adv_out, in_take;

  assign out_rdy       = !out_vld_q || m_axis_tready;
  assign adv_out       = mid_vld_q && out_rdy;
  assign mid_rdy       = !mid_vld_q || out_rdy;
  assign adv_mid       = in_vld_q && mid_rdy;
  assign s_axis_tready = !in_vld_q || mid_rdy;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d  = in_take ? 1'b1 : (adv_mid ? 1'b0 : in_vld_q);
    mid_vld_d = adv_mid ? 1'b1 : (adv_out ? 1'b0 : mid_vld_q);
    out_vld_d = adv_out ? 1'b1 : ((m_axis_tready) ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      mid_vld_q <= mid_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input register: capture range and status on accept
  logic [RANGE_BITS-1:0]       range_q;
  logic [wfps_pkg::STAT_W-1:0] status_q;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      range_q  <= s_axis_tdata[RANGE_BITS-1:0];
      status_q <= s_axis_tdata[RANGE_BITS +: wfps_pkg::STAT_W];
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic signed [PP_W-1:0] prod_p;
  logic signed [PD_W-1:0] prod_d;
  logic signed [PI_W-1:0] prod_i;
  wfps_pkg::mid_ctl_t     mid_ctl;
  logic                   stopped;
  wfps_pkg::res_t         res;

  // State updates happen as an item leaves the input register, so items
  // see the PID state in arrival order.
  wfps_pd_core #(
    .RANGE_BITS(RANGE_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv_mid),
    .range_i   (range_q),
    .status_i  (status_q),
    .cfg_i     (cfg_q),
    .prod_p_o  (prod_p),
    .prod_d_o  (prod_d),
    .prod_i_o  (prod_i),
    .ctl_o     (mid_ctl),
    .stopped_o (stopped)
  );

  wfps_mix #(
    .RANGE_BITS(RANGE_BITS),
    .DUTY_MAX  (DUTY_MAX)
  ) u_mix (
    .clk_i           (clk_i),
    .en_i            (adv_out),
    .prod_p_i        (prod_p),
    .prod_d_i        (prod_d),
    .prod_i_i        (prod_i),
    .ctl_i           (mid_ctl),
    .forward_speed_i (cfg_q.forward_speed),
    .res_o           (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'(res);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `WFPS_ASSERT(a_halt_quiet, m_axis_tvalid && res.halted |-> res.m1 == '0 && res.m2 == '0, "halted result drives a motor")
  `WFPS_ASSERT(a_stop_sticky, stopped |=> stopped, "halt flag cleared without reset")
  `WFPS_NEVER(a_halt_flag, m_axis_tvalid && res.halted && !stopped, "halted result while not stopped")
  `WFPS_ASSERT(a_stall_only, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input blocked without output stall")

endmodule
